// ===== sv/qsu_pkg.sv =====
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types and codes for the linear queue with search and update.
// ----------------------------------------------------------------------------
package qsu_pkg;

  localparam int OP_W   = 3;
  localparam int DATA_W = 16;
  localparam int ST_W   = 2;

  typedef logic [OP_W-1:0]          opcode_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ST_W-1:0]          status_t;

  localparam opcode_t OP_ADD     = 3'd0;
  localparam opcode_t OP_DELETE  = 3'd1;
  localparam opcode_t OP_COUNT   = 3'd2;
  localparam opcode_t OP_SEARCH  = 3'd3;
  localparam opcode_t OP_UPDATE  = 3'd4;
  localparam opcode_t OP_DISPLAY = 3'd5;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch request, read head slot
    logic exec_fire;  // finish a single-result op into the output register
    logic scan_step;  // compare current slot, read the next
    logic resp_fire;  // emit search/update outcome
    logic disp_fire;  // emit current slot, read the next
  } qsu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    opcode_t op;
    logic    empty;
    logic    last;      // slot under the read pointer is the tail
    logic    out_free;  // output register can take a result this cycle
  } qsu_sts_t;

endpackage

// ===== sv/qsu_if.sv =====
// ----------------------------------------------------------------------------
// qsu_req_if / qsu_rsp_if
// Valid/ready channels for queue requests and results.
// ----------------------------------------------------------------------------
interface qsu_req_if import qsu_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  data_t   data_value;
  data_t   replacement;

  modport source (output valid, output opcode, output data_value, output replacement,
                  input ready);
  modport sink   (input valid, input opcode, input data_value, input replacement,
                  output ready);
endinterface

interface qsu_rsp_if import qsu_pkg::*; #(
  parameter int CW = 5
) ();
  logic          valid;
  logic          ready;
  status_t       status;
  data_t         read_value;
  logic [CW-1:0] entry_count;
  logic          last_of_run;

  modport source (output valid, output status, output read_value, output entry_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  input last_of_run, output ready);
endinterface

// ===== sv/qsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// qsu_ctrl
// Sequencer: one request at a time, walks the slots for scan and display.
// ----------------------------------------------------------------------------
module qsu_ctrl import qsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid,
  output logic     req_ready,
  input  qsu_sts_t sts,
  output qsu_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RESP = 3'd3;
  localparam logic [2:0] S_DISP = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       walk_op;

  assign walk_op = (sts.op == OP_SEARCH) || (sts.op == OP_UPDATE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    req_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (walk_op && !sts.empty) begin
          state_nxt = S_SCAN;
        end else if (sts.op == OP_DISPLAY && !sts.empty) begin
          state_nxt = S_DISP;
        end else if (sts.out_free) begin
          cmd.exec_fire = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp_fire = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DISP: begin
        if (sts.out_free) begin
          cmd.disp_fire = 1'b1;
          if (sts.last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== sv/qsu_dp.sv =====
// ----------------------------------------------------------------------------
// qsu_dp
// Slot memory, head/tail indices, compare logic and the result register.
// ----------------------------------------------------------------------------
module qsu_dp import qsu_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW    = 4,
  parameter int CW    = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  qsu_cmd_t      cmd,
  output qsu_sts_t      sts,
  input  opcode_t       in_opcode,
  input  data_t         in_data_value,
  input  data_t         in_replacement,
  output logic          out_valid,
  input  logic          out_ready,
  output status_t       out_status,
  output data_t         out_read_value,
  output logic [CW-1:0] out_entry_count,
  output logic          out_last_of_run
);

  data_t         mem [DEPTH];

  opcode_t       op_r;
  data_t         key_r;
  data_t         rep_r;
  logic [IW-1:0] head_r,  head_nxt;
  logic [IW-1:0] tail_r,  tail_nxt;
  logic          empty_r, empty_nxt;
  logic [IW-1:0] rd_addr_r, rd_addr_nxt;
  data_t         rd_data_r;
  logic          rd_en;
  logic          hit_r, hit_nxt;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  data_t         wr_data;
  logic          full;
  logic          last;
  logic          match;
  logic [IW:0]   span;
  logic [CW-1:0] count;

  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  data_t         out_value_r, out_value_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_free;
  logic          fire;

  assign full     = !empty_r && (tail_r == IW'(DEPTH - 1));
  assign last     = (rd_addr_r == tail_r);
  assign match    = (rd_data_r == key_r);
  assign span     = {1'b0, tail_r} - {1'b0, head_r} + {{IW{1'b0}}, 1'b1};
  assign count    = empty_r ? '0 : CW'(span);
  assign out_free = !out_valid_r || out_ready;
  assign fire     = cmd.exec_fire || cmd.resp_fire || cmd.disp_fire;

  assign sts.op       = op_r;
  assign sts.empty    = empty_r;
  assign sts.last     = last;
  assign sts.out_free = out_free;

  // read port: head on accept, then walks up one slot per step
  assign rd_en       = cmd.accept || ((cmd.scan_step || cmd.disp_fire) && !last);
  assign rd_addr_nxt = cmd.accept ? head_r : rd_addr_r + {{(IW-1){1'b0}}, 1'b1};

  // write port: add at tail, or overwrite the compared slot on update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_r;
    wr_data = rep_r;
    if (cmd.exec_fire && op_r == OP_ADD && !full) begin
      wr_en   = 1'b1;
      wr_addr = empty_r ? '0 : tail_r + {{(IW-1){1'b0}}, 1'b1};
      wr_data = key_r;
    end else if (cmd.scan_step && op_r == OP_UPDATE && match) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr_nxt];
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_addr_r <= rd_addr_nxt;
    if (cmd.accept) begin
      op_r  <= in_opcode;
      key_r <= in_data_value;
      rep_r <= in_replacement;
    end
    hit_r <= hit_nxt;
  end

  assign hit_nxt = cmd.accept ? 1'b0 : (hit_r || (cmd.scan_step && match));

  // index update
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    if (cmd.exec_fire) begin
      case (op_r)
        OP_ADD: begin
          if (empty_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b0;
          end else if (!full) begin
            tail_nxt  = tail_r + {{(IW-1){1'b0}}, 1'b1};
          end
        end
        OP_DELETE: begin
          if (!empty_r) begin
            if (head_r == tail_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b1;
            end else begin
              head_nxt  = head_r + {{(IW-1){1'b0}}, 1'b1};
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  // result register
  always_comb begin
    out_status_nxt = ST_OK;
    out_value_nxt  = '0;
    out_count_nxt  = '0;
    out_last_nxt   = 1'b1;
    if (cmd.exec_fire) begin
      case (op_r)
        OP_ADD:     out_status_nxt = full ? ST_FULL : ST_OK;
        OP_DELETE: begin
          if (empty_r) out_status_nxt = ST_EMPTY;
          else         out_value_nxt  = rd_data_r;
        end
        OP_COUNT:   out_count_nxt  = count;
        OP_SEARCH,
        OP_UPDATE,
        OP_DISPLAY: out_status_nxt = ST_EMPTY;
        default:    out_status_nxt = ST_OK;
      endcase
    end else if (cmd.resp_fire) begin
      out_status_nxt = hit_r ? ST_OK : ST_NOTFOUND;
    end else begin
      out_value_nxt  = rd_data_r;
      out_last_nxt   = last;
    end
  end

  assign out_valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_count_r  <= out_count_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_value_r;
  assign out_entry_count = out_count_r;
  assign out_last_of_run = out_last_r;

endmodule

// ===== sv/linear_queue_with_search_update.sv =====
// ----------------------------------------------------------------------------
// linear_queue_with_search_update
// Non-circular array queue of DEPTH 16-bit entries with search and update.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : requests (opcode, data_value, replacement), valid/ready.
//   out_ch : results (status, read_value, entry_count, last_of_run).
//   One request is worked at a time; in_ch.ready is high only when idle.
//   Add, delete, count, unused opcodes and any op on an empty queue load
//   their one result from the exec state once the result register is free,
//   then go back to idle. Search/update read every held slot, one per
//   cycle through the slot memory's read port, and then wait in the
//   response state for the result register. Display: after the exec state,
//   one entry per cycle while the receiver keeps up, the last one flagged
//   by last_of_run.
//   Adds stop once the tail hits the last slot; space freed at the head is
//   reused only after the queue drains completely.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result; slot contents are not cleared.
//   A stalled receiver holds the result register; the sequencer pauses
//   until it frees up.
// ----------------------------------------------------------------------------
module linear_queue_with_search_update import qsu_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  qsu_req_if.sink   in_ch,
  qsu_rsp_if.source out_ch
);

  // index and count widths; CW must match the width of out_ch
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qsu_cmd_t      cmd;
  qsu_sts_t      sts;
  logic [CW-1:0] entry_count;

  // sequencer: accepts one request, then steps the datapath
  qsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage, indices, compare and output register
  qsu_dp #(
    .DEPTH (DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_ch.opcode),
    .in_data_value   (in_ch.data_value),
    .in_replacement  (in_ch.replacement),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_read_value  (out_ch.read_value),
    .out_entry_count (entry_count),
    .out_last_of_run (out_ch.last_of_run)
  );

  assign out_ch.entry_count = entry_count;

endmodule

// ===== sv/qsu_checker.sv =====
// ----------------------------------------------------------------------------
// qsu_checker
// Port-level checks for the queue, bound to the top level.
// ----------------------------------------------------------------------------
module qsu_checker import qsu_pkg::*; #(
  parameter int CW = 5
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input status_t       status,
  input data_t         read_value,
  input logic [CW-1:0] entry_count,
  input logic          last_of_run
);

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_value))
    else $error("result changed while stalled");

  // one request at a time: no back-to-back accepts
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // any failure status ends the run
  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> last_of_run && read_value == '0 && entry_count == '0)
    else $error("failure result not a lone final result");

  // a count result carries nothing else
  a_count_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && entry_count != '0 |-> last_of_run && read_value == '0)
    else $error("count result mixed with data");

endmodule

bind linear_queue_with_search_update qsu_checker #(.CW(CW)) u_qsu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .read_value  (out_ch.read_value),
  .entry_count (out_ch.entry_count),
  .last_of_run (out_ch.last_of_run)
);
